### sv/pxa2x_pkg.sv
`default_nettype none

package pxa2x_pkg;

    localparam int PixW = 16;

    typedef logic [PixW-1:0] t_pixel;

    // 3x3 neighbourhood, top_left in the lowest bits
    typedef struct packed {
        t_pixel bottom_right;
        t_pixel bottom;
        t_pixel bottom_left;
        t_pixel right;
        t_pixel center;
        t_pixel left;
        t_pixel top_right;
        t_pixel top;
        t_pixel top_left;
    } t_window;

    // 2x2 replacement block, out_top_left in the lowest bits
    typedef struct packed {
        t_pixel out_bottom_right;
        t_pixel out_bottom_left;
        t_pixel out_top_right;
        t_pixel out_top_left;
    } t_block;

    localparam logic FMT_RGB555 = 1'b0;
    localparam logic FMT_RGB565 = 1'b1;
    localparam logic FMT_RESET  = FMT_RGB565;

    // channel LSBs cleared so the halved sum cannot carry across channels
    localparam t_pixel LB_565 = 16'hF7DE;
    localparam t_pixel LB_555 = 16'h7BDE;

    function automatic t_pixel mix_half(input t_pixel dst, input t_pixel src,
                                        input logic fmt);
        t_pixel lb;
        lb = (fmt == FMT_RGB565) ? LB_565 : LB_555;
        return ((src & lb) >> 1) + ((dst & lb) >> 1);
    endfunction

    // d + floor(k*(s-d)/4), k = 1 or 3; result always lies between d and s
    function automatic logic [5:0] blend_chan(input logic [5:0] dch,
                                              input logic [5:0] sch,
                                              input logic three_q);
        logic signed [8:0] diff;
        logic signed [8:0] scaled;
        logic signed [8:0] sum;
        diff   = $signed({3'b000, sch}) - $signed({3'b000, dch});
        scaled = three_q ? (diff + (diff <<< 1)) : diff;
        sum    = $signed({3'b000, dch}) + (scaled >>> 2);
        return sum[5:0];
    endfunction

    function automatic t_pixel mix_q(input t_pixel dst, input t_pixel src,
                                     input logic fmt, input logic three_q);
        logic [5:0] dr, dg, db, sr, sg, sb;
        logic [5:0] rr, rg, rb;
        if (fmt == FMT_RGB565) begin
            dr = {1'b0, dst[15:11]};
            dg = dst[10:5];
            sr = {1'b0, src[15:11]};
            sg = src[10:5];
        end else begin
            dr = {1'b0, dst[14:10]};
            dg = {1'b0, dst[9:5]};
            sr = {1'b0, src[14:10]};
            sg = {1'b0, src[9:5]};
        end
        db = {1'b0, dst[4:0]};
        sb = {1'b0, src[4:0]};
        rr = blend_chan(dr, sr, three_q);
        rg = blend_chan(dg, sg, three_q);
        rb = blend_chan(db, sb, three_q);
        if (fmt == FMT_RGB565) begin
            return {rr[4:0], rg, rb[4:0]};
        end else begin
            return {1'b0, rr[4:0], rg[4:0], rb[4:0]};
        end
    endfunction

endpackage

`default_nettype wire

### sv/pxa2x_kernel.sv
`default_nettype none

module pxa2x_kernel (
    input  var pxa2x_pkg::t_window i_win,
    input  wire                    i_fmt,
    output pxa2x_pkg::t_block      o_blk
);

    always_comb begin
        pxa2x_pkg::t_pixel a, b, c, d, e, f, g, h, i;
        pxa2x_pkg::t_pixel q0, q1, q2, q3;
        logic done;

        a = i_win.top_left;
        b = i_win.top;
        c = i_win.top_right;
        d = i_win.left;
        e = i_win.center;
        f = i_win.right;
        g = i_win.bottom_left;
        h = i_win.bottom;
        i = i_win.bottom_right;

        q0 = e;
        q1 = e;
        q2 = e;
        q3 = e;
        done = 1'b0;

        // horizontal edges
        if (d != f) begin
            if (e != d && d == h && d == i && e != g &&
                (d != g || e != f || a != d) &&
                !(d == a && d == g && e == b && e == f)) begin
                q2 = h;
                q3 = pxa2x_pkg::mix_half(q3, h, i_fmt);
                done = 1'b1;
            end else if (e != f && f == h && f == g && e != i &&
                         (f != i || e != d || c != f) &&
                         !(f == c && f == i && e == b && e == d)) begin
                q2 = pxa2x_pkg::mix_half(q2, h, i_fmt);
                q3 = h;
                done = 1'b1;
            end
        end

        // vertical edges; blends chain on whatever the horizontal pass left
        if (b != h) begin
            if (e != b && (a != b || b != c || e != h)) begin
                if (b == d && b == g && e != a &&
                    !(d == a && d == c && e == h && e == f)) begin
                    q0 = pxa2x_pkg::mix_q(q0, b, i_fmt, 1'b1);
                    q2 = pxa2x_pkg::mix_q(q2, b, i_fmt, 1'b0);
                    done = 1'b1;
                end else if (b == f && b == i && e != c &&
                             !(f == c && f == a && e == h && e == d)) begin
                    q1 = pxa2x_pkg::mix_q(q1, b, i_fmt, 1'b1);
                    q3 = pxa2x_pkg::mix_q(q3, b, i_fmt, 1'b0);
                    done = 1'b1;
                end
            end
            if (e != h && (g != h || e != b || h != i)) begin
                if (h == d && h == a && e != g &&
                    !(d == g && d == i && e == b && e == f)) begin
                    q2 = pxa2x_pkg::mix_q(q2, h, i_fmt, 1'b1);
                    q0 = pxa2x_pkg::mix_q(q0, h, i_fmt, 1'b0);
                    done = 1'b1;
                end else if (h == f && h == c && e != i &&
                             !(f == i && f == g && e == b && e == d)) begin
                    q3 = pxa2x_pkg::mix_q(q3, h, i_fmt, 1'b1);
                    q1 = pxa2x_pkg::mix_q(q1, h, i_fmt, 1'b0);
                    done = 1'b1;
                end
            end
        end

        if (!done) begin
            if (b != h && d != f) begin
                // diagonal corners
                if (b == d && e != d &&
                    !(e == a && b == c && e == f) &&
                    !(b == a && b == g) &&
                    !(d == a && d == c && e == f && g != d && g != e)) begin
                    q0 = pxa2x_pkg::mix_half(q0, b, i_fmt);
                end
                if (b == f && e != f &&
                    !(e == c && b == a && e == d) &&
                    !(b == c && b == i) &&
                    !(f == a && f == c && e == d && i != f && i != e)) begin
                    q1 = pxa2x_pkg::mix_half(q1, b, i_fmt);
                end
                if (h == d && (e != g || e != d) &&
                    !(e == g && h == i && e == f) &&
                    !(h == g && h == a) &&
                    !(d == g && d == i && e == f && a != d && a != e)) begin
                    q2 = pxa2x_pkg::mix_half(q2, h, i_fmt);
                end
                if (h == f && (e != i || e != f) &&
                    !(e == i && h == g && e == d) &&
                    !(h == i && h == c) &&
                    !(f == g && f == i && e == d && c != f && i != e)) begin
                    q3 = pxa2x_pkg::mix_half(q3, h, i_fmt);
                end
            end else if (d == b && d == f && d == h && d != e) begin
                // lone pixel surrounded by one colour
                if (d == g || d == c) begin
                    q1 = pxa2x_pkg::mix_half(q1, d, i_fmt);
                    q2 = q1;
                end
                if (d == a || d == i) begin
                    q0 = pxa2x_pkg::mix_half(q0, d, i_fmt);
                    q3 = q0;
                end
            end
        end

        o_blk.out_top_left     = q0;
        o_blk.out_top_right    = q1;
        o_blk.out_bottom_left  = q2;
        o_blk.out_bottom_right = q3;
    end

endmodule

`default_nettype wire

### sv/pixel_art_2x_upscale_kernel.sv
`default_nettype none

// Channel   Dir  Bits  Contents
// s_axis    in   144   3x3 window, 16-bit pixels, top_left lowest
// m_axis    out  64    2x2 block, 16-bit pixels, out_top_left lowest
// i_cfg_*   in   1     pixel_format (0 = RGB555, 1 = RGB565)
//
// One window per clock, sustained while m_axis takes results. An accepted request
// sits in the window register; the rule logic loads the result register from it
// once the output register is free, and the result then shows on m_axis.
// Reset (synchronous, active low) empties both stages and selects RGB565.
// A stalled result holds in the output register; the window register keeps
// accepting until it too is full.

module pixel_art_2x_upscale_kernel (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // top_left, top, top_right, left, center, right, bottom_left, bottom,
    // bottom_right
    input  wire  [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // out_top_left, out_top_right, out_bottom_left, out_bottom_right
    output logic [63:0]  m_axis_tdata,
    input  wire          i_cfg_we,
    input  wire          i_cfg_wdata
);

    logic                 r_in_vld, n_in_vld;
    logic                 r_out_vld, n_out_vld;
    logic                 r_pixel_format, n_pixel_format;
    pxa2x_pkg::t_window   r_win;
    pxa2x_pkg::t_block    r_blk;
    pxa2x_pkg::t_block    w_blk;
    logic                 w_out_free;
    logic                 w_adv;
    logic                 w_in_acc;

    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign w_adv         = r_in_vld && w_out_free;
    assign s_axis_tready = !r_in_vld || w_out_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_vld = r_in_vld;
        if (w_in_acc) begin
            n_in_vld = 1'b1;
        end else if (w_adv) begin
            n_in_vld = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (w_adv) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end
        n_pixel_format = i_cfg_we ? i_cfg_wdata : r_pixel_format;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_pixel_format <= pxa2x_pkg::FMT_RESET;
        end else begin
            r_in_vld       <= n_in_vld;
            r_out_vld      <= n_out_vld;
            r_pixel_format <= n_pixel_format;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_win <= pxa2x_pkg::t_window'(s_axis_tdata);
        end
        if (w_adv) begin
            r_blk <= w_blk;
        end
    end

    pxa2x_kernel u_kernel (
        .i_win (r_win),
        .i_fmt (r_pixel_format),
        .o_blk (w_blk)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = 64'(r_blk);

endmodule

`default_nettype wire

### sv/pxa2x_checker.sv
`default_nettype none

module pxa2x_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire [143:0] s_axis_tdata,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [63:0]  m_axis_tdata
);

    // a result refused downstream stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a waiting request keeps its window until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("request changed while waiting");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    // with nothing waiting at the output the input side must take a request
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 (!m_axis_tvalid || m_axis_tready)
        |=> m_axis_tvalid)
        else $error("accepted request did not reach the output");

endmodule

bind pixel_art_2x_upscale_kernel pxa2x_checker u_pxa2x_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
